>>> hw/rtl/mcr_pkg.sv
// ----------------------------------------------------------------------------
// MCTP control responder package
// Shared types, command codes, completion codes and the version lookup used by
// the responder controller and datapath.
// ----------------------------------------------------------------------------
package mcr_pkg;

  localparam int NUM_INTERFACES_DEF = 3;

  localparam int FUNC_W  = 8;
  localparam int IFC_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int MP_W    = 12;
  localparam int CPL_W   = 2;
  localparam int VER_W   = 32;
  localparam int IFE_W   = 24;
  localparam int UUID_W  = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [MP_W-1:0] VDM_LEN_RESET = 12'd64;

  localparam logic [FUNC_W-1:0] FN_SET_EID       = 8'h01;
  localparam logic [FUNC_W-1:0] FN_GET_EID       = 8'h02;
  localparam logic [FUNC_W-1:0] FN_GET_UUID      = 8'h03;
  localparam logic [FUNC_W-1:0] FN_GET_VERSION   = 8'h04;
  localparam logic [FUNC_W-1:0] FN_GET_MSG_TYPE  = 8'h05;
  localparam logic [FUNC_W-1:0] FN_GET_VENDOR    = 8'h06;
  localparam logic [FUNC_W-1:0] FN_RESOLVE_RSP   = 8'h07;
  localparam logic [FUNC_W-1:0] FN_PREP_DISC     = 8'h0B;
  localparam logic [FUNC_W-1:0] FN_EP_DISC       = 8'h0C;
  localparam logic [FUNC_W-1:0] FN_DISC_NOTIFY   = 8'h0D;
  localparam logic [FUNC_W-1:0] FN_QUERY_RATE    = 8'h11;
  localparam logic [FUNC_W-1:0] FN_REQ_TX_RATE   = 8'h12;
  localparam logic [FUNC_W-1:0] FN_UPD_RATE      = 8'h13;
  localparam logic [FUNC_W-1:0] FN_QUERY_IFCS    = 8'h14;

  localparam logic [1:0] OP_SET       = 2'd0;
  localparam logic [1:0] OP_FORCE     = 2'd1;
  localparam logic [1:0] OP_RESET     = 2'd2;
  localparam logic [1:0] OP_SET_DISC  = 2'd3;

  localparam logic [BYTE_W-1:0] EID_NULL      = 8'h00;
  localparam logic [BYTE_W-1:0] EID_BROADCAST = 8'hFF;

  localparam logic [IFC_W-1:0] IFC_SMBUS = 2'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_VDM_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UUID_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UUID_LOW  = 2'd2;

  localparam logic [7:0] VER_F0 = 8'hF0;
  localparam logic [7:0] VER_F1 = 8'hF1;
  localparam logic [7:0] VER_F2 = 8'hF2;
  localparam logic [7:0] VER_F3 = 8'hF3;

  typedef enum logic [CPL_W-1:0] {
    CPL_OK      = 2'd0,
    CPL_INVALID = 2'd1,
    CPL_UNSUP   = 2'd2,
    CPL_MSGTYPE = 2'd3
  } cpl_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic has_result;
  } dp_sts_t;

  typedef struct packed {
    logic             found;
    logic [VER_W-1:0] word;
  } ver_t;

  function automatic ver_t ver_lookup(input logic [BYTE_W-1:0] msg_type);
    ver_t v;
    v.found = 1'b1;
    if (msg_type inside {8'hFF, 8'h00}) begin
      v.word = {VER_F1, VER_F3, VER_F1, 8'h00};
    end else if (msg_type inside {8'h01, 8'h06}) begin
      v.word = {VER_F1, VER_F0, VER_F0, 8'h00};
    end else if (msg_type inside {8'h02, 8'h03}) begin
      v.word = {VER_F1, VER_F2, VER_F3, 8'h00};
    end else if (msg_type inside {8'h04, 8'h05}) begin
      v.word = {VER_F1, VER_F0, VER_F1, 8'h00};
    end else if (msg_type inside {8'h7E, 8'h7F}) begin
      v.word = {VER_F1, VER_F2, VER_F0, 8'h00};
    end else begin
      v.found = 1'b0;
      v.word  = '0;
    end
    return v;
  endfunction

endpackage

>>> hw/rtl/mcr_ctrl.sv
// ----------------------------------------------------------------------------
// MCTP control responder controller
// Sequences capture and execution of one request and owns the result valid.
// ----------------------------------------------------------------------------
module mcr_ctrl import mcr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.capture   = 1'b0;
    cmd.exec      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_r || out_ready) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = sts.has_result;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/mcr_dp.sv
// ----------------------------------------------------------------------------
// MCTP control responder datapath
// Request registers, per-interface endpoint state, configuration registers,
// command decode and the result registers.
// ----------------------------------------------------------------------------
module mcr_dp import mcr_pkg::*; #(
  parameter int NUM_INTERFACES = NUM_INTERFACES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [IFC_W-1:0]      in_interface_id,
  input  logic [BYTE_W-1:0]     in_req_byte_a,
  input  logic [BYTE_W-1:0]     in_req_byte_b,
  input  logic [MP_W-1:0]       in_max_payload,
  output logic [CPL_W-1:0]      out_completion,
  output logic [BYTE_W-1:0]     out_eid_out,
  output logic [VER_W-1:0]      out_version_word,
  output logic [IFE_W-1:0]      out_interface_eids,
  output logic                  out_eid_rate_limit,
  output logic [UUID_W-1:0]     out_uuid_hi_out,
  output logic [UUID_W-1:0]     out_uuid_lo_out
);

  logic [FUNC_W-1:0] func_r;
  logic [IFC_W-1:0]  ifc_r;
  logic [BYTE_W-1:0] byte_a_r;
  logic [BYTE_W-1:0] byte_b_r;
  logic [MP_W-1:0]   mp_r;

  logic [BYTE_W-1:0] eid_r  [NUM_INTERFACES];
  logic              disc_r [NUM_INTERFACES];

  logic [MP_W-1:0]   vdm_len_r;
  logic [UUID_W-1:0] uuid_hi_r;
  logic [UUID_W-1:0] uuid_lo_r;

  cpl_t              cpl_r;
  logic [BYTE_W-1:0] eid_out_r;
  logic [VER_W-1:0]  ver_r;
  logic [IFE_W-1:0]  ifeids_r;
  logic              rl_r;
  logic [UUID_W-1:0] uh_r;
  logic [UUID_W-1:0] ul_r;

  logic              in_range;
  logic [BYTE_W-1:0] cur_eid;
  logic              cur_disc;
  logic              vdm;
  ver_t              ver_res;

  cpl_t              cpl_nxt;
  logic [BYTE_W-1:0] eid_out_nxt;
  logic [VER_W-1:0]  ver_nxt;
  logic [IFE_W-1:0]  ifeids_nxt;
  logic              rl_nxt;
  logic [UUID_W-1:0] uh_nxt;
  logic [UUID_W-1:0] ul_nxt;
  logic              has_result;
  logic              wr_eid;
  logic              wr_disc;
  logic              disc_val;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r   <= in_func;
      ifc_r    <= in_interface_id;
      byte_a_r <= in_req_byte_a;
      byte_b_r <= in_req_byte_b;
      mp_r     <= in_max_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vdm_len_r <= VDM_LEN_RESET;
      uuid_hi_r <= '0;
      uuid_lo_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VDM_LEN:   vdm_len_r <= cfg_data[MP_W-1:0];
        CFG_UUID_HIGH: uuid_hi_r <= cfg_data;
        CFG_UUID_LOW:  uuid_lo_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_INTERFACES; i++) begin
      if (!rst_n) begin
        eid_r[i]  <= '0;
        disc_r[i] <= 1'b0;
      end else if (cmd.exec && (32'(ifc_r) == i)) begin
        if (wr_eid) begin
          eid_r[i] <= byte_b_r;
        end
        if (wr_disc) begin
          disc_r[i] <= disc_val;
        end
      end
    end
  end

  always_comb begin
    cur_eid  = '0;
    cur_disc = 1'b0;
    in_range = 1'b0;
    for (int i = 0; i < NUM_INTERFACES; i++) begin
      if (32'(ifc_r) == i) begin
        cur_eid  = eid_r[i];
        cur_disc = disc_r[i];
        in_range = 1'b1;
      end
    end
  end

  always_comb begin
    ifeids_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      if (i < NUM_INTERFACES) begin
        ifeids_nxt[i*BYTE_W +: BYTE_W] = eid_r[i];
      end
    end
  end

  assign vdm     = (mp_r == vdm_len_r);
  assign ver_res = ver_lookup(byte_a_r);

  always_comb begin
    cpl_nxt     = CPL_OK;
    eid_out_nxt = '0;
    ver_nxt     = '0;
    rl_nxt      = 1'b0;
    uh_nxt      = '0;
    ul_nxt      = '0;
    has_result  = 1'b1;
    wr_eid      = 1'b0;
    wr_disc     = 1'b0;
    disc_val    = 1'b0;
    case (func_r)
      FN_SET_EID: begin
        case (byte_a_r[1:0])
          OP_SET, OP_FORCE: begin
            if (byte_b_r == EID_NULL || byte_b_r == EID_BROADCAST) begin
              cpl_nxt = CPL_INVALID;
            end else begin
              wr_eid      = 1'b1;
              wr_disc     = 1'b1;
              disc_val    = 1'b1;
              eid_out_nxt = in_range ? byte_b_r : '0;
            end
          end
          OP_RESET: begin
            cpl_nxt = CPL_INVALID;
          end
          OP_SET_DISC: begin
            wr_disc     = 1'b1;
            disc_val    = 1'b1;
            eid_out_nxt = cur_eid;
          end
          default: begin
            cpl_nxt = CPL_INVALID;
          end
        endcase
      end
      FN_GET_EID: begin
        eid_out_nxt = cur_disc ? cur_eid : '0;
      end
      FN_GET_UUID: begin
        uh_nxt = uuid_hi_r;
        ul_nxt = uuid_lo_r;
      end
      FN_GET_VERSION: begin
        if (ver_res.found) begin
          ver_nxt = ver_res.word;
        end else begin
          cpl_nxt = CPL_MSGTYPE;
        end
      end
      FN_GET_MSG_TYPE, FN_UPD_RATE: begin
      end
      FN_GET_VENDOR: begin
        has_result = (byte_a_r == '0);
      end
      FN_RESOLVE_RSP, FN_DISC_NOTIFY: begin
        has_result = 1'b0;
      end
      FN_PREP_DISC: begin
        if (!vdm) begin
          cpl_nxt = CPL_UNSUP;
        end else begin
          wr_disc = 1'b1;
        end
      end
      FN_EP_DISC: begin
        if (!vdm) begin
          cpl_nxt = CPL_UNSUP;
        end else if (cur_disc) begin
          has_result = 1'b0;
        end
      end
      FN_QUERY_RATE: begin
        rl_nxt = (ifc_r != IFC_SMBUS);
      end
      FN_REQ_TX_RATE: begin
        if (ifc_r == IFC_SMBUS) begin
          cpl_nxt = CPL_INVALID;
        end
      end
      FN_QUERY_IFCS: begin
      end
      default: begin
        cpl_nxt = CPL_UNSUP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && has_result) begin
      cpl_r     <= cpl_nxt;
      eid_out_r <= eid_out_nxt;
      ver_r     <= ver_nxt;
      ifeids_r  <= (func_r == FN_QUERY_IFCS) ? ifeids_nxt : '0;
      rl_r      <= rl_nxt;
      uh_r      <= uh_nxt;
      ul_r      <= ul_nxt;
    end
  end

  assign sts.has_result     = has_result;
  assign out_completion     = cpl_r;
  assign out_eid_out        = eid_out_r;
  assign out_version_word   = ver_r;
  assign out_interface_eids = ifeids_r;
  assign out_eid_rate_limit = rl_r;
  assign out_uuid_hi_out    = uh_r;
  assign out_uuid_lo_out    = ul_r;

endmodule

>>> hw/rtl/mctp_control_responder_core.sv
// A request is captured into the request registers on its transfer, and in the
// execute step its response, if any, is registered in the result registers.
// Requests are accepted only while idle, not before the last one is executed;
// execution waits only while an earlier response is held.
// Reset (synchronous, active low) clears all endpoint IDs and discovered flags,
// loads the default configuration and clears the response valid.
// ----------------------------------------------------------------------------
// MCTP control responder core
// Answers decoded MCTP control requests and keeps per-interface endpoint state.
// ----------------------------------------------------------------------------
module mctp_control_responder_core import mcr_pkg::*; #(
  parameter int NUM_INTERFACES = NUM_INTERFACES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [IFC_W-1:0]      in_interface_id,
  input  logic [BYTE_W-1:0]     in_req_byte_a,
  input  logic [BYTE_W-1:0]     in_req_byte_b,
  input  logic [MP_W-1:0]       in_max_payload,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CPL_W-1:0]      out_completion,
  output logic [BYTE_W-1:0]     out_eid_out,
  output logic [VER_W-1:0]      out_version_word,
  output logic [IFE_W-1:0]      out_interface_eids,
  output logic                  out_eid_rate_limit,
  output logic [UUID_W-1:0]     out_uuid_hi_out,
  output logic [UUID_W-1:0]     out_uuid_lo_out
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mcr_dp #(
    .NUM_INTERFACES (NUM_INTERFACES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_func            (in_func),
    .in_interface_id    (in_interface_id),
    .in_req_byte_a      (in_req_byte_a),
    .in_req_byte_b      (in_req_byte_b),
    .in_max_payload     (in_max_payload),
    .out_completion     (out_completion),
    .out_eid_out        (out_eid_out),
    .out_version_word   (out_version_word),
    .out_interface_eids (out_interface_eids),
    .out_eid_rate_limit (out_eid_rate_limit),
    .out_uuid_hi_out    (out_uuid_hi_out),
    .out_uuid_lo_out    (out_uuid_lo_out)
  );

endmodule
